@@ hdl/trd_pkg.sv @@
// ---------------------------------------------------------------------------
// trd_pkg
// shared types and constants for the tga run-length pixel decoder
// ---------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

	localparam logic [1:0] CFG_PIXEL_BYTES  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

	localparam int unsigned HDR_REPEAT_BIT = 7;
	localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;

	localparam logic [2:0] PB_RESET = 3'd4;
	localparam logic [2:0] PB_MIN   = 3'd1;
	localparam logic [2:0] PB_MAX   = 3'd4;

	typedef struct packed {
		logic accept;
		logic run_step;
	} trd_cmd_t;

	typedef struct packed {
		logic lit_result;
		logic rep_start;
		logic run_final;
	} trd_status_t;

endpackage

`default_nettype wire

@@ hdl/trd_ctrl.sv @@
// ---------------------------------------------------------------------------
// trd_ctrl
// handshake and run sequencing for the decoder
// ---------------------------------------------------------------------------
`default_nettype none

module trd_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire                  out_stall,
	input  trd_pkg::trd_status_t status,
	output trd_pkg::trd_cmd_t    cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free    = !out_valid_q || !out_stall;
	assign in_stall     = (state_q != ST_IDLE) || !slot_free;
	assign cmd.accept   = in_valid && !in_stall;
	assign cmd.run_step = (state_q == ST_RUN) && slot_free;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && status.rep_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.run_step && status.run_final) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((cmd.accept && status.lit_result) || cmd.run_step) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/trd_datapath.sv @@
// ---------------------------------------------------------------------------
// trd_datapath
// configuration, packet state, pixel assembly and result registers
// ---------------------------------------------------------------------------
`default_nettype none

module trd_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [1:0]           cfg_index,
	input  wire  [15:0]          cfg_data,
	input  wire  [7:0]           data_byte,
	input  trd_pkg::trd_cmd_t    cmd,
	output trd_pkg::trd_status_t status,
	output logic [31:0]          pixel_first,
	output logic [31:0]          pixel_second,
	output logic [1:0]           pixel_count,
	output logic                 run_last,
	output logic                 image_done
);

	logic [2:0]  pb_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] total_q;
	logic        expect_q;
	logic        repeat_q;
	logic [7:0]  left_q;
	logic [1:0]  pos_q;
	logic [31:0] emitted_q;
	logic [23:0] gather_q;
	logic [31:0] pixel_q;
	logic [7:0]  run_q;

	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] product;
	logic [2:0]  pb_eff;
	logic        active;
	logic        complete;
	logic [31:0] pix;
	logic [31:0] remain;
	logic [7:0]  run_init;
	logic [1:0]  step_cnt;
	logic [7:0]  run_next;
	logic [31:0] emit_next;
	logic        step_last;

	// total pixel count follows the write so the next byte sees it
	assign mul_a   = (cfg_we && cfg_index == trd_pkg::CFG_IMAGE_WIDTH) ? cfg_data : width_q;
	assign mul_b   = (cfg_we && cfg_index == trd_pkg::CFG_IMAGE_HEIGHT) ? cfg_data : height_q;
	assign product = mul_a * mul_b;

	always_comb begin
		if (pb_q < trd_pkg::PB_MIN) begin
			pb_eff = trd_pkg::PB_MIN;
		end else if (pb_q > trd_pkg::PB_MAX) begin
			pb_eff = trd_pkg::PB_MAX;
		end else begin
			pb_eff = pb_q;
		end
	end

	assign active   = emitted_q < total_q;
	assign complete = ({1'b0, pos_q} + 3'd1) >= pb_eff;
	assign pix      = (pos_q == 2'd0) ? {24'd0, data_byte}
	                : ({8'd0, gather_q} | ({24'd0, data_byte} << {pos_q, 3'b000}));

	assign remain   = total_q - emitted_q;
	assign run_init = (remain < {24'd0, left_q}) ? remain[7:0] : left_q;

	assign step_cnt  = (run_q >= 8'd2) ? 2'd2 : 2'd1;
	assign run_next  = run_q - {6'd0, step_cnt};
	assign emit_next = emitted_q + {30'd0, step_cnt};
	assign step_last = (run_next == 8'd0);

	assign status.lit_result = active && !expect_q && complete && !repeat_q;
	assign status.rep_start  = active && !expect_q && complete && repeat_q;
	assign status.run_final  = (run_q <= 8'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pb_q      <= trd_pkg::PB_RESET;
			width_q   <= 16'd0;
			height_q  <= 16'd0;
			total_q   <= 32'd0;
			expect_q  <= 1'b1;
			repeat_q  <= 1'b0;
			left_q    <= 8'd0;
			pos_q     <= 2'd0;
			emitted_q <= 32'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					trd_pkg::CFG_PIXEL_BYTES:  pb_q     <= cfg_data[2:0];
					trd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
					trd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				total_q <= product;
			end
			if (cmd.accept && active) begin
				if (expect_q) begin
					repeat_q <= data_byte[trd_pkg::HDR_REPEAT_BIT];
					left_q   <= {1'b0, data_byte[6:0] & trd_pkg::HDR_COUNT_MASK} + 8'd1;
					pos_q    <= 2'd0;
					expect_q <= 1'b0;
				end else if (!complete) begin
					pos_q <= pos_q + 2'd1;
				end else begin
					pos_q <= 2'd0;
					if (repeat_q) begin
						left_q   <= 8'd0;
						expect_q <= 1'b1;
					end else begin
						emitted_q <= emitted_q + 32'd1;
						if (left_q != 8'd0) begin
							left_q <= left_q - 8'd1;
						end
						if (left_q <= 8'd1) begin
							expect_q <= 1'b1;
						end
					end
				end
			end else if (cmd.run_step) begin
				emitted_q <= emit_next;
			end
		end
	end

	// pixel assembly and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept && active && !expect_q) begin
			if (!complete) begin
				gather_q <= pix[23:0];
			end else if (repeat_q) begin
				pixel_q <= pix;
				run_q   <= run_init;
			end else begin
				pixel_first  <= pix;
				pixel_second <= 32'd0;
				pixel_count  <= 2'd1;
				run_last     <= 1'b1;
				image_done   <= (emitted_q + 32'd1) >= total_q;
			end
		end else if (cmd.run_step) begin
			run_q        <= run_next;
			pixel_first  <= pixel_q;
			pixel_second <= (step_cnt == 2'd2) ? pixel_q : 32'd0;
			pixel_count  <= step_cnt;
			run_last     <= step_last;
			image_done   <= step_last && (emit_next >= total_q);
		end
	end

endmodule

`default_nettype wire

@@ hdl/tga_rle_pixel_decoder_unit.sv @@
// a literal pixel shows in the cycle after its last byte is accepted
// a repeat run enters ST_RUN, then one result per cycle unless stalled, up to two pixels each
// throughput: one byte per cycle unless stalled; a repeat pixel holds input through its run
// the run sequencer in ST_RUN holds input; output register allows overlap with a waiting result
// reset: asynchronous active low, expects a packet header, pixel_bytes 4, image size zero
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// tga run-length packet decoder, one compressed byte per request
// ---------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] pixel_first,
	output logic [31:0] pixel_second,
	output logic [1:0]  pixel_count,
	output logic        run_last,
	output logic        image_done
);

	trd_pkg::trd_cmd_t    cmd;
	trd_pkg::trd_status_t status;

	trd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	trd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.status       (status),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.pixel_count  (pixel_count),
		.run_last     (run_last),
		.image_done   (image_done)
	);

endmodule

`default_nettype wire

@@ hdl/trd_checker.sv @@
// ---------------------------------------------------------------------------
// trd_checker
// port level checks for the tga run-length pixel decoder
// ---------------------------------------------------------------------------
`default_nettype none

module trd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_stall,
	input wire [31:0] pixel_first,
	input wire [31:0] pixel_second,
	input wire [1:0]  pixel_count
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_first) && $stable(pixel_count))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_count == 2'd1 || pixel_count == 2'd2)
		else $error("bad pixel count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_count == 2'd2 |-> pixel_second == pixel_first)
		else $error("pixel pair differs");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_count != 2'd2 |-> pixel_second == 32'd0)
		else $error("second pixel not cleared");

endmodule

bind tga_rle_pixel_decoder_unit trd_checker u_trd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_first  (pixel_first),
	.pixel_second (pixel_second),
	.pixel_count  (pixel_count)
);

`default_nettype wire
